// ===== sv/sorted_coo_sparse_matrix_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted sparse matrix table
// Short forms of the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_COO_SPARSE_MATRIX_TABLE_MACROS_SVH
`define SORTED_COO_SPARSE_MATRIX_TABLE_MACROS_SVH

// same-cycle implication, held off during reset
`define SCOO_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, held off during reset
`define SCOO_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/scoo_pkg.sv =====
// ----------------------------------------------------------------------------
// scoo_pkg
// Types and constants shared by the sparse matrix table modules.
// ----------------------------------------------------------------------------
package scoo_pkg;

  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int PORT_VW = 32;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // op codes on the input word
  typedef enum logic [2:0] {
    OP_SET  = 3'd0,
    OP_GET  = 3'd1,
    OP_SROW = 3'd2,
    OP_SCOL = 3'd3,
    OP_DROW = 3'd4,
    OP_DCOL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // command class decided by the front end
  typedef enum logic [2:0] {
    K_SET, K_GET, K_SROW, K_SCOL, K_DROW, K_DCOL, K_RANGE, K_UNK
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [PORT_VW-1:0] val;
    logic [DIM_W-1:0]   len;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SRCH, B_DEL, B_INS, B_INSW, B_WALK, B_FLUSH, B_EMIT
  } bstate_t;

endpackage

// ===== sv/scoo_ram.sv =====
// ----------------------------------------------------------------------------
// scoo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scoo_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/scoo_front.sv =====
// ----------------------------------------------------------------------------
// scoo_front
// Takes input words, checks them against the configured size and queues
// classified commands for the back end.
// ----------------------------------------------------------------------------
module scoo_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [scoo_pkg::DIM_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    op,
  input  logic [scoo_pkg::IDX_W-1:0]    row_index,
  input  logic [scoo_pkg::IDX_W-1:0]    col_index,
  input  logic signed [scoo_pkg::PORT_VW-1:0] new_value,
  output logic                          q_valid,
  output scoo_pkg::cmd_t                q_cmd,
  input  logic                          q_pop
);
  import scoo_pkg::*;

  logic [DIM_W-1:0] num_rows, num_cols, nr, nc;
  logic [DIM_W-1:0] r_ext, c_ext;
  cmd_t             cls;
  cmd_t             fifo [2];
  logic             wp, rp;
  logic [1:0]       fcnt;
  logic             push, pop;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) num_rows <= cfg_data;
      else                       num_cols <= cfg_data;
    end
  end

  // zero acts as one, oversize clamps
  always_comb begin
    nr = num_rows;
    nc = num_cols;
    if (num_rows == '0) nr = DIM_W'(1);
    else if (num_rows > DIM_W'(MAX_DIM)) nr = DIM_W'(MAX_DIM);
    if (num_cols == '0) nc = DIM_W'(1);
    else if (num_cols > DIM_W'(MAX_DIM)) nc = DIM_W'(MAX_DIM);
  end

  assign r_ext = {1'b0, row_index};
  assign c_ext = {1'b0, col_index};

  // classify
  always_comb begin
    cls.row = row_index;
    cls.col = col_index;
    cls.val = new_value;
    cls.len = nc;
    case (op)
      OP_SET:  cls.kind = (r_ext >= nr || c_ext >= nc) ? K_RANGE : K_SET;
      OP_GET:  cls.kind = (r_ext >= nr || c_ext >= nc) ? K_RANGE : K_GET;
      OP_SROW: cls.kind = (r_ext >= nr) ? K_RANGE : K_SROW;
      OP_SCOL: cls.kind = (c_ext >= nc) ? K_RANGE : K_SCOL;
      OP_DROW: cls.kind = (r_ext >= nr) ? K_RANGE : K_DROW;
      OP_DCOL: begin
        cls.kind = (c_ext >= nc) ? K_RANGE : K_DCOL;
        cls.len  = nr;
      end
      default: cls.kind = K_UNK;
    endcase
  end

  // two-word queue to the back end
  assign in_stall = (fcnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fcnt != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fcnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/scoo_back.sv =====
// ----------------------------------------------------------------------------
// scoo_back
// Executes queued commands on the ordered entry store: search, shift,
// update and scans, one entry per cycle while the output is not stalled, with a registered output word.
// ----------------------------------------------------------------------------
`include "sorted_coo_sparse_matrix_table_macros.svh"

module scoo_back #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  scoo_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [scoo_pkg::PORT_VW-1:0] value,
  output logic [scoo_pkg::IDX_W-1:0]        out_row,
  output logic [scoo_pkg::IDX_W-1:0]        out_col,
  output logic                              found,
  output logic                              last,
  output logic [1:0]                        status,
  output logic [scoo_pkg::DIM_W-1:0]        entry_count
);
  import scoo_pkg::*;

  localparam int SW = (VALUE_WIDTH < PORT_VW) ? VALUE_WIDTH : PORT_VW;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = 2 * IDX_W + SW;

  bstate_t          state, state_next;
  cmd_t             cmd, cmd_next;
  logic [CW-1:0]    idx, idx_next, count, count_next;
  logic [CW-1:0]    idx_inc, idx_dec, cnt_dec;
  logic [AW-1:0]    p, p_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [SW-1:0]    res_val, res_val_next;
  logic             res_found, res_found_next;
  status_t          res_status, res_status_next;
  logic             pend_v, pend_v_next;
  logic [SW-1:0]    pend_val, pend_val_next;
  logic [IDX_W-1:0] pend_row, pend_row_next, pend_col, pend_col_next;

  // RAM port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata, new_word;

  // output staging
  logic             o_load, o_found, o_last, out_free;
  logic [SW-1:0]    o_val;
  logic [IDX_W-1:0] o_row, o_col;
  status_t          o_status;

  // entry fields and compares
  logic [IDX_W-1:0] e_row, e_col, epos;
  logic [SW-1:0]    e_val, nv;
  logic             nv_zero, have, hit, row_kind, sparse, sel, is_last;

  scoo_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e_row    = rdata[MW-1 -: IDX_W];
  assign e_col    = rdata[MW-IDX_W-1 -: IDX_W];
  assign e_val    = rdata[SW-1:0];
  assign nv       = cmd.val[SW-1:0];
  assign nv_zero  = (nv == '0);
  assign new_word = {cmd.row, cmd.col, nv};
  assign idx_inc  = idx + 1'b1;
  assign idx_dec  = idx - 1'b1;
  assign cnt_dec  = count - 1'b1;
  assign have     = (idx < count);
  assign hit      = have && ({e_row, e_col} == {cmd.row, cmd.col});
  assign row_kind = (cmd.kind == K_SROW) || (cmd.kind == K_DROW);
  assign sparse   = (cmd.kind == K_SROW) || (cmd.kind == K_SCOL);
  assign sel      = row_kind ? (e_row == cmd.row) : (e_col == cmd.col);
  assign epos     = row_kind ? e_col : e_row;
  assign is_last  = ({1'b0, pos} == cmd.len - 1'b1);
  assign out_free = !out_valid || !out_stall;

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      count  <= '0;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend_v <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    idx        <= idx_next;
    p          <= p_next;
    pos        <= pos_next;
    res_val    <= res_val_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    pend_val   <= pend_val_next;
    pend_row   <= pend_row_next;
    pend_col   <= pend_col_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    idx_next        = idx;
    count_next      = count;
    p_next          = p;
    pos_next        = pos;
    res_val_next    = res_val;
    res_found_next  = res_found;
    res_status_next = res_status;
    pend_v_next     = pend_v;
    pend_val_next   = pend_val;
    pend_row_next   = pend_row;
    pend_col_next   = pend_col;
    q_pop    = 1'b0;
    re       = 1'b0;
    raddr    = idx_inc[AW-1:0];
    we       = 1'b0;
    waddr    = idx[AW-1:0];
    wdata    = rdata;
    o_load   = 1'b0;
    o_val    = '0;
    o_row    = cmd.row;
    o_col    = cmd.col;
    o_found  = 1'b0;
    o_last   = 1'b0;
    o_status = ST_OK;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop           = 1'b1;
          cmd_next        = q_cmd;
          idx_next        = '0;
          pos_next        = '0;
          pend_v_next     = 1'b0;
          res_val_next    = '0;
          res_found_next  = 1'b0;
          res_status_next = ST_OK;
          case (q_cmd.kind)
            K_RANGE: begin
              res_status_next = ST_RANGE;
              state_next      = B_EMIT;
            end
            K_UNK: state_next = B_EMIT;
            K_SET, K_GET: begin
              re         = 1'b1;
              raddr      = '0;
              state_next = B_SRCH;
            end
            default: begin
              re         = 1'b1;
              raddr      = '0;
              state_next = B_WALK;
            end
          endcase
        end
      end
      // linear search for the first key not below the target
      B_SRCH: begin
        if (!have || {e_row, e_col} >= {cmd.row, cmd.col}) begin
          if (cmd.kind == K_GET) begin
            res_val_next   = hit ? e_val : '0;
            res_found_next = hit;
            state_next     = B_EMIT;
          end else if (hit && nv_zero) begin
            if (idx_inc < count) begin
              re         = 1'b1;
              raddr      = idx_inc[AW-1:0];
              idx_next   = idx_inc;
              state_next = B_DEL;
            end else begin
              count_next = cnt_dec;
              state_next = B_EMIT;
            end
          end else if (hit) begin
            we             = 1'b1;
            wdata          = new_word;
            res_val_next   = nv;
            res_found_next = 1'b1;
            state_next     = B_EMIT;
          end else if (nv_zero) begin
            state_next = B_EMIT;
          end else if (count == CW'(CAPACITY)) begin
            res_status_next = ST_FULL;
            state_next      = B_EMIT;
          end else if (!have) begin
            we             = 1'b1;
            wdata          = new_word;
            count_next     = count + 1'b1;
            res_val_next   = nv;
            res_found_next = 1'b1;
            state_next     = B_EMIT;
          end else begin
            re         = 1'b1;
            raddr      = cnt_dec[AW-1:0];
            p_next     = idx[AW-1:0];
            idx_next   = cnt_dec;
            state_next = B_INS;
          end
        end else begin
          re       = 1'b1;
          idx_next = idx_inc;
        end
      end
      // close the gap: entry idx moves down one place
      B_DEL: begin
        we    = 1'b1;
        waddr = idx_dec[AW-1:0];
        if (idx_inc < count) begin
          re       = 1'b1;
          idx_next = idx_inc;
        end else begin
          count_next = cnt_dec;
          state_next = B_EMIT;
        end
      end
      // open a gap: entry idx moves up one place
      B_INS: begin
        we    = 1'b1;
        waddr = idx_inc[AW-1:0];
        if (idx[AW-1:0] == p) begin
          state_next = B_INSW;
        end else begin
          re       = 1'b1;
          raddr    = idx_dec[AW-1:0];
          idx_next = idx_dec;
        end
      end
      B_INSW: begin
        we             = 1'b1;
        waddr          = p;
        wdata          = new_word;
        count_next     = count + 1'b1;
        res_val_next   = nv;
        res_found_next = 1'b1;
        state_next     = B_EMIT;
      end
      // ordered walk over the store for scans
      B_WALK: begin
        if (sparse) begin
          if (!have) begin
            state_next = B_FLUSH;
          end else if (!sel) begin
            re       = 1'b1;
            idx_next = idx_inc;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              o_load  = 1'b1;
              o_val   = pend_val;
              o_row   = pend_row;
              o_col   = pend_col;
              o_found = 1'b1;
            end
            pend_v_next   = 1'b1;
            pend_val_next = e_val;
            pend_row_next = e_row;
            pend_col_next = e_col;
            re            = 1'b1;
            idx_next      = idx_inc;
          end
        end else begin
          if (have && !sel) begin
            re       = 1'b1;
            idx_next = idx_inc;
          end else if (out_free) begin
            o_load = 1'b1;
            o_last = is_last;
            o_row  = row_kind ? cmd.row : pos;
            o_col  = row_kind ? pos : cmd.col;
            if (have && epos == pos) begin
              o_val    = e_val;
              o_found  = 1'b1;
              re       = 1'b1;
              idx_next = idx_inc;
            end
            if (is_last) state_next = B_IDLE;
            else         pos_next   = pos + 1'b1;
          end
        end
      end
      // last word of a sparse scan, or the empty-line word
      B_FLUSH: begin
        if (out_free) begin
          o_load = 1'b1;
          o_last = 1'b1;
          if (pend_v) begin
            o_val   = pend_val;
            o_row   = pend_row;
            o_col   = pend_col;
            o_found = 1'b1;
          end
          state_next = B_IDLE;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          o_load     = 1'b1;
          o_val      = res_val;
          o_found    = res_found;
          o_status   = res_status;
          o_last     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      value       <= PORT_VW'(o_val);
      out_row     <= o_row;
      out_col     <= o_col;
      found       <= o_found;
      last        <= o_last;
      status      <= o_status;
      entry_count <= DIM_W'(count);
    end
  end

  `SCOO_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY), "entry count over capacity")
  `SCOO_ASSERT_NEXT(a_count_hold, clk, rst, state != B_SRCH && state != B_DEL && state != B_INSW, $stable(count), "entry count moved outside an update")
  `SCOO_ASSERT_IMPL(a_write_state, clk, rst, we, state == B_SRCH || state == B_DEL || state == B_INS || state == B_INSW, "store written outside a set")
  `SCOO_ASSERT_IMPL(a_walk_idx, clk, rst, state == B_WALK, idx <= count, "scan pointer past the stored entries")

endmodule

// ===== sv/sorted_coo_sparse_matrix_table.sv =====
// A set or get searches the entries linearly, one entry a cycle; a delete then
// shifts the entries past the hit down in the same forward pass, while an insert
// shifts them up in a second pass from the last entry back to the insert point.
// Scans walk the stored entries in order and emit result words while the output is not stalled.
// One command is executed at a time; a two-word queue takes inputs meanwhile.
// Reset empties the table at once (no clearing pass) and sets both sizes to 64.
// ----------------------------------------------------------------------------
// sorted_coo_sparse_matrix_table
// Sparse matrix kept as ordered (row, column, value) entries, with set, get
// and sparse or dense row and column scans.
// ----------------------------------------------------------------------------
module sorted_coo_sparse_matrix_table #(
  parameter int CAPACITY    = 64,
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [scoo_pkg::DIM_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        op,
  input  logic [scoo_pkg::IDX_W-1:0]        row_index,
  input  logic [scoo_pkg::IDX_W-1:0]        col_index,
  input  logic signed [scoo_pkg::PORT_VW-1:0] new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [scoo_pkg::PORT_VW-1:0] value,
  output logic [scoo_pkg::IDX_W-1:0]        out_row,
  output logic [scoo_pkg::IDX_W-1:0]        out_col,
  output logic                              found,
  output logic                              last,
  output logic [1:0]                        status,
  output logic [scoo_pkg::DIM_W-1:0]        entry_count
);
  import scoo_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  scoo_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .row_index (row_index),
    .col_index (col_index),
    .new_value (new_value),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  scoo_back #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .out_row     (out_row),
    .out_col     (out_col),
    .found       (found),
    .last        (last),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
